// ----- rtl/vdp_pkg.sv -----
// ----------------------------------------------------------------------------
// vdp_pkg - shared types and helpers for the double pendulum stepper
// Sequencer states, register indices, commands, fixed widths and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package vdp_pkg;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned DIVD_W    = 66;  // |d| * |err| dividend
   localparam int unsigned DIVS_W    = 34;  // 2 * dist divisor

   localparam logic [CSR_IDX_W-1:0] REG_ANCHOR_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANCHOR_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRAVITY       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_LENGTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_LENGTH = 3'd4;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_PLACE   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_DT, S_GRAV, S_ACC, S_INT, S_DIFF, S_SQX, S_SQY,
      S_SQRT, S_MUL, S_FIX, S_DIV, S_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      logic signed [37:0] hi;
      logic signed [37:0] lo;
      hi = 38'sd2147483647;
      lo = -38'sd2147483648;
      if (v > hi) return 32'sh7FFF_FFFF;
      if (v < lo) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

// ----- rtl/verlet_double_pendulum_step.sv -----
// ----------------------------------------------------------------------------
// verlet_double_pendulum_step - position Verlet step for a double pendulum
// Sequencer around a shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
// One request beat either places a bob (sets its current and previous
// position) or advances both bobs by one time step, then one response beat
// returns both positions and the degenerate flag. A place is answered in the
// cycle after its request beat. An advance runs the gravity term on the
// multiplier, then for each of the two rope constraints integration and
// squaring, a square root and, per axis, a multiply, a divider start and a
// divide (one quotient bit a cycle over 66 bits); the bit-serial divider
// dominates. A constraint whose distance comes out zero skips its correction
// and sets degenerate. Response stalls lengthen an item. The request side is
// ready only when no item is in flight. Positions and gravity are signed
// Q16.16, lengths unsigned Q15.16; every new position saturates to 32 bits.
// ----------------------------------------------------------------------------
module verlet_double_pendulum_step (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vdp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_data,
   // request
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic                            req_bob_select,
   input  logic signed [31:0]              req_place_x,
   input  logic signed [31:0]              req_place_y,
   input  logic [15:0]                     req_time_step,
   // response
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_bob1_x_out,
   output logic signed [31:0]              rsp_bob1_y_out,
   output logic signed [31:0]              rsp_bob2_x_out,
   output logic signed [31:0]              rsp_bob2_y_out,
   output logic                            rsp_degenerate
);
   vdp_pkg::state_type state_ff, state_in;

   // config registers
   logic signed [31:0] anchor_x_ff, anchor_y_ff, gravity_ff;
   logic [30:0]        len1_ff, len2_ff;

   // bob state
   logic signed [31:0] b1x_ff, b1y_ff, b1ox_ff, b1oy_ff;
   logic signed [31:0] b2x_ff, b2y_ff, b2ox_ff, b2oy_ff;
   logic signed [31:0] b1x_in, b1y_in, b1ox_in, b1oy_in;
   logic signed [31:0] b2x_in, b2y_in, b2ox_in, b2oy_in;

   // working registers
   logic [15:0]        dt_ff, dt_in;
   logic signed [33:0] acc_ff, acc_in;
   logic               sel_ff, sel_in;     // 0: bob 1 constraint, 1: bob 2
   logic               axis_ff, axis_in;   // 0: x, 1: y
   logic [31:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic               negx_ff, negx_in, negy_ff, negy_in;
   logic               shift_ff, shift_in;
   logic [63:0]        sqx_ff, sqx_in;
   logic [32:0]        dist_ff, dist_in;
   logic [33:0]        em_ff, em_in;
   logic               eneg_ff, eneg_in;
   logic               degen_ff, degen_in;
   logic               sqrt_go_ff, sqrt_go_in;

   // shared units
   logic [31:0]                  mul_a, mul_b;
   logic [63:0]                  mul_p;
   logic                         sqrt_start, sqrt_busy;
   logic                         div_start, div_busy;
   logic [31:0]                  root;
   logic [vdp_pkg::DIVD_W-1:0]   div_num, div_q;
   logic [vdp_pkg::DIVS_W-1:0]   div_den;

   // combinational helpers
   logic               req_fire, csr_fire;
   logic [31:0]        grav_mag;
   logic [64:0]        grav_round;
   logic [32:0]        grav_t;
   logic signed [31:0] cur_x, cur_y, old_x, old_y;
   logic signed [37:0] nx, ny;
   logic signed [31:0] par_x, par_y, bob_x, bob_y;
   logic signed [32:0] dx, dy;
   logic [32:0]        dist_now;
   logic signed [34:0] err;
   logic [31:0]        ax_sel;
   logic               neg_sel;
   logic signed [31:0] bob_sel;
   logic [35:0]        off;
   logic signed [37:0] corr;
   logic signed [31:0] corr_sat;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == vdp_pkg::S_IDLE);
   assign rsp_valid = (state_ff == vdp_pkg::S_OUT);

   vdp_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   vdp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqx_ff + mul_p),
      .busy     (sqrt_busy),
      .root     (root)
   );

   vdp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // gravity: |g| * dt^2 >> 32, rounded half away from zero
   assign grav_mag   = gravity_ff[31] ? 32'(-33'(gravity_ff)) : 32'(gravity_ff);
   assign grav_round = {1'b0, mul_p} + 65'h0_8000_0000;
   assign grav_t     = grav_round[64:32];

   // integrate the bob picked by sel
   assign cur_x = sel_ff ? b2x_ff  : b1x_ff;
   assign cur_y = sel_ff ? b2y_ff  : b1y_ff;
   assign old_x = sel_ff ? b2ox_ff : b1ox_ff;
   assign old_y = sel_ff ? b2oy_ff : b1oy_ff;
   assign nx    = 38'(cur_x) + 38'(cur_x) - 38'(old_x);
   assign ny    = 38'(cur_y) + 38'(cur_y) - 38'(old_y) + 38'(acc_ff);

   // distance to parent; bob 2 hangs from the updated bob 1
   assign par_x = sel_ff ? b1x_ff : anchor_x_ff;
   assign par_y = sel_ff ? b1y_ff : anchor_y_ff;
   assign bob_x = cur_x;
   assign bob_y = cur_y;
   assign dx    = 33'(par_x) - 33'(bob_x);
   assign dy    = 33'(par_y) - 33'(bob_y);

   assign dist_now = shift_ff ? {root, 1'b0} : {1'b0, root};
   assign err      = $signed({4'b0, (sel_ff ? len2_ff : len1_ff)})
                   - $signed({2'b0, dist_now});

   // correction of one axis
   assign ax_sel  = axis_ff ? ay_ff : ax_ff;
   assign neg_sel = axis_ff ? negy_ff : negx_ff;
   assign bob_sel = axis_ff ? bob_y : bob_x;
   assign div_num = vdp_pkg::DIVD_W'(mul_p)
                  + (vdp_pkg::DIVD_W'(em_ff[33:32]) * vdp_pkg::DIVD_W'(ax_sel) << 32);
   assign div_den = {dist_ff, 1'b0};
   assign off     = div_q[35:0];
   assign corr    = (neg_sel != eneg_ff) ? 38'(bob_sel) + $signed({2'b0, off})
                                         : 38'(bob_sel) - $signed({2'b0, off});
   assign corr_sat = vdp_pkg::sat32(corr);

   // square root starts in the cycle the second square lands
   assign sqrt_go_in = (state_ff == vdp_pkg::S_SQY);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vdp_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = (req_cmd == vdp_pkg::CMD_PLACE) ? vdp_pkg::S_OUT : vdp_pkg::S_DT;
            end
         end
         vdp_pkg::S_DT:   state_in = vdp_pkg::S_GRAV;
         vdp_pkg::S_GRAV: state_in = vdp_pkg::S_ACC;
         vdp_pkg::S_ACC:  state_in = vdp_pkg::S_INT;
         vdp_pkg::S_INT:  state_in = vdp_pkg::S_DIFF;
         vdp_pkg::S_DIFF: state_in = vdp_pkg::S_SQX;
         vdp_pkg::S_SQX:  state_in = vdp_pkg::S_SQY;
         vdp_pkg::S_SQY:  state_in = vdp_pkg::S_SQRT;
         vdp_pkg::S_SQRT: begin
            if (!sqrt_busy && !sqrt_go_ff) begin
               if (dist_now == '0) begin
                  state_in = sel_ff ? vdp_pkg::S_OUT : vdp_pkg::S_INT;
               end else begin
                  state_in = vdp_pkg::S_MUL;
               end
            end
         end
         vdp_pkg::S_MUL:  state_in = vdp_pkg::S_FIX;
         vdp_pkg::S_FIX:  state_in = vdp_pkg::S_DIV;
         vdp_pkg::S_DIV: begin
            if (!div_busy) begin
               if (!axis_ff)     state_in = vdp_pkg::S_MUL;
               else if (!sel_ff) state_in = vdp_pkg::S_INT;
               else              state_in = vdp_pkg::S_OUT;
            end
         end
         vdp_pkg::S_OUT: begin
            if (rsp_ready) state_in = vdp_pkg::S_IDLE;
         end
         default: state_in = vdp_pkg::S_IDLE;
      endcase
   end

   // datapath and unit control per state
   always_comb begin
      b1x_in = b1x_ff;  b1y_in = b1y_ff;  b1ox_in = b1ox_ff;  b1oy_in = b1oy_ff;
      b2x_in = b2x_ff;  b2y_in = b2y_ff;  b2ox_in = b2ox_ff;  b2oy_in = b2oy_ff;
      dt_in    = dt_ff;
      acc_in   = acc_ff;
      sel_in   = sel_ff;
      axis_in  = axis_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      negx_in  = negx_ff;
      negy_in  = negy_ff;
      shift_in = shift_ff;
      sqx_in   = sqx_ff;
      dist_in  = dist_ff;
      em_in    = em_ff;
      eneg_in  = eneg_ff;
      degen_in = degen_ff;
      mul_a    = '0;
      mul_b    = '0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         vdp_pkg::S_IDLE: begin
            if (req_fire) begin
               dt_in    = req_time_step;
               degen_in = 1'b0;
               sel_in   = 1'b0;
               if (req_cmd == vdp_pkg::CMD_PLACE) begin
                  if (req_bob_select) begin
                     b2x_in = req_place_x;  b2ox_in = req_place_x;
                     b2y_in = req_place_y;  b2oy_in = req_place_y;
                  end else begin
                     b1x_in = req_place_x;  b1ox_in = req_place_x;
                     b1y_in = req_place_y;  b1oy_in = req_place_y;
                  end
               end
            end
         end
         vdp_pkg::S_DT: begin
            mul_a = 32'(dt_ff);
            mul_b = 32'(dt_ff);
         end
         vdp_pkg::S_GRAV: begin
            mul_a = grav_mag;
            mul_b = mul_p[31:0];
         end
         vdp_pkg::S_ACC: begin
            acc_in = gravity_ff[31] ? -$signed({1'b0, grav_t}) : $signed({1'b0, grav_t});
         end
         vdp_pkg::S_INT: begin
            if (sel_ff) begin
               b2ox_in = b2x_ff;  b2oy_in = b2y_ff;
               b2x_in  = vdp_pkg::sat32(nx);
               b2y_in  = vdp_pkg::sat32(ny);
            end else begin
               b1ox_in = b1x_ff;  b1oy_in = b1y_ff;
               b1x_in  = vdp_pkg::sat32(nx);
               b1y_in  = vdp_pkg::sat32(ny);
            end
         end
         vdp_pkg::S_DIFF: begin
            ax_in    = dx[32] ? 32'(-dx) : dx[31:0];
            ay_in    = dy[32] ? 32'(-dy) : dy[31:0];
            negx_in  = dx[32];
            negy_in  = dy[32];
         end
         vdp_pkg::S_SQX: begin
            shift_in = ax_ff[31] | ay_ff[31];
            mul_a    = (ax_ff[31] | ay_ff[31]) ? ax_ff >> 1 : ax_ff;
            mul_b    = mul_a;
         end
         vdp_pkg::S_SQY: begin
            sqx_in = mul_p;
            mul_a  = shift_ff ? ay_ff >> 1 : ay_ff;
            mul_b  = mul_a;
         end
         vdp_pkg::S_SQRT: begin
            // radicand sx^2 + sy^2 is on offer in the first cycle here
            sqrt_start = sqrt_go_ff;
            if (!sqrt_busy && !sqrt_go_ff) begin
               dist_in = dist_now;
               em_in   = err[34] ? 34'(-err) : err[33:0];
               eneg_in = err[34];
               axis_in = 1'b0;
               if (dist_now == '0) begin
                  degen_in = 1'b1;
                  sel_in   = 1'b1;
               end
            end
         end
         vdp_pkg::S_MUL: begin
            mul_a = ax_sel;
            mul_b = em_ff[31:0];
         end
         vdp_pkg::S_FIX: begin
            div_start = 1'b1;
         end
         vdp_pkg::S_DIV: begin
            if (!div_busy) begin
               axis_in = 1'b1;
               if (!axis_ff) begin
                  if (sel_ff) b2x_in = corr_sat;
                  else        b1x_in = corr_sat;
               end else begin
                  if (sel_ff) b2y_in = corr_sat;
                  else        b1y_in = corr_sat;
                  sel_in = 1'b1;
               end
            end
         end
         vdp_pkg::S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_go_ff <= 1'b0;
      end else begin
         sqrt_go_ff <= sqrt_go_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= vdp_pkg::S_IDLE;
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         gravity_ff  <= '0;
         len1_ff     <= '0;
         len2_ff     <= '0;
         b1x_ff <= '0;  b1y_ff <= '0;  b1ox_ff <= '0;  b1oy_ff <= '0;
         b2x_ff <= '0;  b2y_ff <= '0;  b2ox_ff <= '0;  b2oy_ff <= '0;
         degen_ff <= 1'b0;
         sel_ff   <= 1'b0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            unique case (csr_index)
               vdp_pkg::REG_ANCHOR_X:      anchor_x_ff <= csr_data;
               vdp_pkg::REG_ANCHOR_Y:      anchor_y_ff <= csr_data;
               vdp_pkg::REG_GRAVITY:       gravity_ff  <= csr_data;
               vdp_pkg::REG_FIRST_LENGTH:  len1_ff     <= csr_data[30:0];
               vdp_pkg::REG_SECOND_LENGTH: len2_ff     <= csr_data[30:0];
               default: begin
               end
            endcase
         end
         b1x_ff <= b1x_in;  b1y_ff <= b1y_in;  b1ox_ff <= b1ox_in;  b1oy_ff <= b1oy_in;
         b2x_ff <= b2x_in;  b2y_ff <= b2y_in;  b2ox_ff <= b2ox_in;  b2oy_ff <= b2oy_in;
         degen_ff <= degen_in;
         sel_ff   <= sel_in;
         axis_ff  <= axis_in;
      end
      dt_ff    <= dt_in;
      acc_ff   <= acc_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      negx_ff  <= negx_in;
      negy_ff  <= negy_in;
      shift_ff <= shift_in;
      sqx_ff   <= sqx_in;
      dist_ff  <= dist_in;
      em_ff    <= em_in;
      eneg_ff  <= eneg_in;
   end

   assign rsp_bob1_x_out = b1x_ff;
   assign rsp_bob1_y_out = b1y_ff;
   assign rsp_bob2_x_out = b2x_ff;
   assign rsp_bob2_y_out = b2y_ff;
   assign rsp_degenerate = degen_ff;

   // never ready for a new beat while a response is pending
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request accepted while response pending");

   // divider only started when idle
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_busy)
      else $error("divider restarted while busy");

   // the divider is running once the sequencer leaves S_FIX
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == vdp_pkg::S_FIX) |=> div_busy)
      else $error("divider did not start");

   // a place beat reports no degenerate constraint
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == vdp_pkg::CMD_PLACE) |=> (rsp_valid && !rsp_degenerate))
      else $error("place response malformed");

endmodule

// ----- rtl/vdp_mul.sv -----
// ----------------------------------------------------------------------------
// vdp_mul - shared multiplier
// Unsigned 32 x 32 product, registered.
// ----------------------------------------------------------------------------
module vdp_mul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);
   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= 64'(a) * 64'(b);
   end

   assign p = p_ff;
endmodule

// ----- rtl/vdp_sqrt.sv -----
// ----------------------------------------------------------------------------
// vdp_sqrt - iterative integer square root
// Floor root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vdp_sqrt (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  radicand,
   output logic         busy,
   output logic [31:0]  root
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic [63:0] trial;

   always_comb begin
      trial   = root_ff + bit_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         busy_in = !bit_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign busy = busy_ff;
   assign root = root_ff[31:0];
endmodule

// ----- rtl/vdp_div.sv -----
// ----------------------------------------------------------------------------
// vdp_div - iterative restoring divider
// One quotient bit per cycle; quotient rounded half up at the end.
// ----------------------------------------------------------------------------
module vdp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [vdp_pkg::DIVD_W-1:0]   dividend,
   input  logic [vdp_pkg::DIVS_W-1:0]   divisor,
   output logic                         busy,
   output logic [vdp_pkg::DIVD_W-1:0]   quotient
);
   localparam int unsigned CNT_W = $clog2(vdp_pkg::DIVD_W + 1);

   logic [vdp_pkg::DIVS_W-1:0] r_ff, r_in;
   logic [vdp_pkg::DIVD_W-1:0] q_ff, q_in;
   logic [vdp_pkg::DIVS_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [vdp_pkg::DIVS_W:0]   t;
   logic                       ge;
   logic                       round_up;

   always_comb begin
      t       = {r_ff, q_ff[vdp_pkg::DIVD_W-1]};
      ge      = t >= {1'b0, d_ff};
      r_in    = r_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         r_in    = '0;
         q_in    = dividend;
         d_in    = divisor;
         cnt_in  = CNT_W'(vdp_pkg::DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in    = ge ? vdp_pkg::DIVS_W'(t - {1'b0, d_ff}) : t[vdp_pkg::DIVS_W-1:0];
         q_in    = {q_ff[vdp_pkg::DIVD_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      r_ff   <= r_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

   // remainder at least half the divisor rounds up
   assign round_up = {r_ff, 1'b0} >= {1'b0, d_ff};
   assign busy     = busy_ff;
   assign quotient = q_ff + vdp_pkg::DIVD_W'(round_up);
endmodule

// ----- bench/vdp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdp_checker - watches the double pendulum stepper and scores its responses
// Mirrors the register writes and request beats into its own copy of the bob
// state, works out the expected positions and flag, and compares each
// response beat with the oldest expectation.
// ----------------------------------------------------------------------------
module vdp_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [vdp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_cmd,
   input  logic                          req_bob_select,
   input  logic signed [31:0]            req_place_x,
   input  logic signed [31:0]            req_place_y,
   input  logic [15:0]                   req_time_step,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [31:0]            rsp_bob1_x_out,
   input  logic signed [31:0]            rsp_bob1_y_out,
   input  logic signed [31:0]            rsp_bob2_x_out,
   input  logic signed [31:0]            rsp_bob2_y_out,
   input  logic                          rsp_degenerate,
   output int                            fail_count,
   output int                            pending,
   output int                            degen_seen
);
   typedef struct packed {
      logic signed [31:0] b1x, b1y, b2x, b2y;
      logic               degen;
   } pose_type;

   pose_type pose_q[$];

   logic signed [31:0] anc_x, anc_y, grav;
   logic [30:0]        len1, len2;
   logic signed [31:0] p1x, p1y, o1x, o1y, p2x, p2y, o2x, o2y;

   function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // pull one bob toward its rest length; returns 1 when the distance is zero
   function automatic logic pull(input logic signed [63:0] px, input logic signed [63:0] py,
                                 inout logic signed [31:0] bx, inout logic signed [31:0] by,
                                 input logic [30:0] len);
      logic signed [63:0] dx, dy, err;
      logic [63:0]        ax, ay, sx, sy, span, em;
      logic [127:0]       prod, q, r, dv;
      logic               sh;
      dx = px - bx;
      dy = py - by;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      sh = (ax >= 64'h8000_0000) || (ay >= 64'h8000_0000);
      sx = ax >> sh;
      sy = ay >> sh;
      span = root_floor(sx * sx + sy * sy) << sh;
      if (span == 0) return 1'b1;
      err = $signed({33'd0, len}) - $signed(span);
      em = err < 0 ? -err : err;
      dv = {64'd0, span} << 1;
      prod = {64'd0, ax} * {64'd0, em};
      q = prod / dv;
      r = prod % dv;
      if (r >= dv - r) q = q + 1;
      bx = clamp(64'(bx) - (((dx < 0) != (err < 0)) ? -$signed(q[63:0]) : $signed(q[63:0])));
      prod = {64'd0, ay} * {64'd0, em};
      q = prod / dv;
      r = prod % dv;
      if (r >= dv - r) q = q + 1;
      by = clamp(64'(by) - (((dy < 0) != (err < 0)) ? -$signed(q[63:0]) : $signed(q[63:0])));
      return 1'b0;
   endfunction

   task automatic predict_pose(input logic cmd, input logic sel, input logic signed [31:0] x,
                               input logic signed [31:0] y, input logic [15:0] dt);
      logic [63:0]        m, g, t;
      logic signed [63:0] acc, nx, ny;
      pose_type           e;
      e.degen = 1'b0;
      if (cmd == vdp_pkg::CMD_PLACE) begin
         if (sel) begin
            p2x = x; o2x = x; p2y = y; o2y = y;
         end else begin
            p1x = x; o1x = x; p1y = y; o1y = y;
         end
      end else begin
         g = grav < 0 ? -64'(grav) : 64'(grav);
         m = g * (64'(dt) * 64'(dt));
         t = (m + 64'h8000_0000) >> 32;
         acc = grav < 0 ? -$signed(t) : $signed(t);
         nx = 2 * 64'(p1x) - o1x;
         ny = 2 * 64'(p1y) - o1y + acc;
         o1x = p1x; o1y = p1y; p1x = clamp(nx); p1y = clamp(ny);
         if (pull(anc_x, anc_y, p1x, p1y, len1)) e.degen = 1'b1;
         nx = 2 * 64'(p2x) - o2x;
         ny = 2 * 64'(p2y) - o2y + acc;
         o2x = p2x; o2y = p2y; p2x = clamp(nx); p2y = clamp(ny);
         if (pull(p1x, p1y, p2x, p2y, len2)) e.degen = 1'b1;
      end
      e.b1x = p1x; e.b1y = p1y; e.b2x = p2x; e.b2y = p2y;
      pose_q.push_back(e);
   endtask

   always @(posedge clock) begin
      pose_type e;
      if (reset) begin
         anc_x <= 0; anc_y <= 0; grav <= 0; len1 <= 0; len2 <= 0;
         p1x = 0; p1y = 0; o1x = 0; o1y = 0; p2x = 0; p2y = 0; o2x = 0; o2y = 0;
         pose_q.delete();
         fail_count <= 0;
         degen_seen <= 0;
         pending    <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               vdp_pkg::REG_ANCHOR_X:      anc_x <= csr_data;
               vdp_pkg::REG_ANCHOR_Y:      anc_y <= csr_data;
               vdp_pkg::REG_GRAVITY:       grav  <= csr_data;
               vdp_pkg::REG_FIRST_LENGTH:  len1  <= csr_data[30:0];
               vdp_pkg::REG_SECOND_LENGTH: len2  <= csr_data[30:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pose_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("response beat with nothing expected");
            end else begin
               e = pose_q.pop_front();
               if (e.degen) degen_seen <= degen_seen + 1;
               if (rsp_bob1_x_out !== e.b1x || rsp_bob1_y_out !== e.b1y ||
                   rsp_bob2_x_out !== e.b2x || rsp_bob2_y_out !== e.b2y ||
                   rsp_degenerate !== e.degen) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: exp %0d %0d %0d %0d %b got %0d %0d %0d %0d %b",
                              e.b1x, e.b1y, e.b2x, e.b2y, e.degen, rsp_bob1_x_out,
                              rsp_bob1_y_out, rsp_bob2_x_out, rsp_bob2_y_out,
                              rsp_degenerate);
               end
            end
         end
         // request after response: a new beat cannot be answered in its own cycle
         if (req_valid && req_ready)
            predict_pose(req_cmd, req_bob_select, req_place_x, req_place_y, req_time_step);
         pending <= pose_q.size();
      end
   end
endmodule

// ----- bench/verlet_double_pendulum_step_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// verlet_double_pendulum_step_tb - stimulus and verdict for the pendulum stepper
// Writes anchor, gravity and rope lengths in several phases, sends directed
// corner beats then random place/advance sequences under varied back-pressure;
// the checker beside the block scores every response.
// ----------------------------------------------------------------------------
module verlet_double_pendulum_step_tb;

   localparam int WATCHDOG = 20000;  // limit on cycles with no beat on any channel
   localparam logic [vdp_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [vdp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic req_cmd = 0;
   logic req_bob_select = 0;
   logic signed [31:0] req_place_x = 0;
   logic signed [31:0] req_place_y = 0;
   logic [15:0] req_time_step = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_bob1_x_out, rsp_bob1_y_out, rsp_bob2_x_out, rsp_bob2_y_out;
   logic rsp_degenerate;
   int fail_count, pending, degen_seen;

   int send_idle_pct = 0;   // chance the sender sits out a cycle
   int recv_stall_pct = 0;  // chance the receiver stalls a cycle
   bit hold_off = 0;        // long receiver stall for the pressure test
   int items_sent = 0;
   int quiet_cycles = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   verlet_double_pendulum_step DUT (.*);

   vdp_checker u_checker (.*);

   // receiver: random stall, or a long hold while hold_off is set
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("watchdog expired with %0d responses pending", pending);
         $display("verlet_double_pendulum_step_tb failed");
         $finish;
      end
   end

   // valid stays up after the beat; the next write or config_phase replaces it
   task automatic write_reg(input logic [vdp_pkg::CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // valid stays up after the beat; the next send replaces it, an idle cycle or drain drops it
   task automatic send_beat(input logic cmd, input logic sel, input logic [31:0] x,
                            input logic [31:0] y, input logic [15:0] dt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_bob_select <= sel;
      req_place_x <= x;
      req_place_y <= y;
      req_time_step <= dt;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // idle point for register writes: all answers in, then the block's latency
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(400 << 16)) - (200 << 16);
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   task automatic config_phase(input logic [31:0] ax, input logic [31:0] ay,
                               input logic [31:0] g, input logic [31:0] l1,
                               input logic [31:0] l2);
      drain();
      write_reg(vdp_pkg::REG_ANCHOR_X, ax);
      write_reg(vdp_pkg::REG_ANCHOR_Y, ay);
      write_reg(vdp_pkg::REG_GRAVITY, g);
      write_reg(vdp_pkg::REG_FIRST_LENGTH, l1);
      write_reg(vdp_pkg::REG_SECOND_LENGTH, l2);
      write_reg(REG_UNUSED, $urandom);  // unused index, must be dropped
      csr_valid <= 1'b0;
   endtask

   // a well-formed run: place both bobs then a string of advances
   task automatic swing(input int steps);
      send_beat(vdp_pkg::CMD_PLACE, 1'b0, rand_pos(), rand_pos(), 16'($urandom));
      send_beat(vdp_pkg::CMD_PLACE, 1'b1, rand_pos(), rand_pos(), 16'($urandom));
      repeat (steps)
         send_beat(vdp_pkg::CMD_ADVANCE, 1'($urandom), $urandom, $urandom,
                   $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1200)));
   endtask

   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: zero state gives two zero distances, then corners
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'hFFFF);
      config_phase(32'h0064_0000, 32'h0032_0000, 32'h01F4_0000, 32'h0064_0000,
                   32'h0050_0000);
      send_beat(vdp_pkg::CMD_PLACE, 1'b0, 32'h00C8_0000, 32'h0032_0000, 16'd0);
      send_beat(vdp_pkg::CMD_PLACE, 1'b1, 32'h012C_0000, 32'h0032_0000, 16'd0);
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'd1092);
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b1, 0, 0, 16'hFFFF);
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'd0);
      send_beat(vdp_pkg::CMD_PLACE, 1'b0, 32'h0064_0000, 32'h0032_0000, 16'd0);  // on anchor
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'd0);
      send_beat(vdp_pkg::CMD_PLACE, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
      send_beat(vdp_pkg::CMD_PLACE, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'hFFFF);
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'hFFFF);
      config_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF);
      send_beat(vdp_pkg::CMD_PLACE, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
      send_beat(vdp_pkg::CMD_PLACE, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'hFFFF);
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'h8000);
      config_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'hFFFF);
      send_beat(vdp_pkg::CMD_PLACE, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 16'd0);
      send_beat(vdp_pkg::CMD_ADVANCE, 1'b0, 0, 0, 16'h5555);

      // random phases: idle mixes, fresh settings each time
      for (k = 0; k < 8; k++) begin
         config_phase($signed($urandom_range(640 << 16)) - (320 << 16),
                      $signed($urandom_range(480 << 16)) - (240 << 16),
                      k == 7 ? $urandom : $signed($urandom_range(1000 << 16)) - (200 << 16),
                      k == 6 ? $urandom : $urandom_range(300 << 16),
                      k == 6 ? $urandom : $urandom_range(300 << 16));
         case (k % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         while (items_sent < 25 + (k + 1) * 140) begin
            if ($urandom_range(9) == 0)
               send_beat(1'($urandom), 1'($urandom), rand_pos(), rand_pos(), 16'($urandom));
            else swing($urandom_range(20));
         end
      end

      // pressure: receiver holds off while requests keep coming
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_off = 1;
            repeat (1500) @(posedge clock);
            hold_off = 0;
         end
         swing(4);
      join

      drain();
      $display("sent %0d request beats over reset defaults and 11 register sets,", items_sent);
      $display("%0d answers flagged a degenerate constraint", degen_seen);
      if (fail_count == 0) $display("verlet_double_pendulum_step_tb passed");
      else $display("verlet_double_pendulum_step_tb failed");
      $finish;
   end
endmodule
